// ===== hdl/csv_quoted_field_tokenizer_unit_macros.svh =====
// Assertion macros for the CSV tokenizer.
`ifndef CSV_QUOTED_FIELD_TOKENIZER_UNIT_MACROS_SVH
`define CSV_QUOTED_FIELD_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTH
`define CSVTOK_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("csvtok check failed: label");
`define CSVTOK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("csvtok check failed: label");
`else
`define CSVTOK_ASSERT_SAME(label, clk, rstn, ante, cons)
`define CSVTOK_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/csvtok_pkg.sv =====
package csvtok_pkg;

    localparam int MAX_FIELDS = 64;
    localparam int FIELD_W    = 6;
    localparam logic [FIELD_W-1:0] FIELD_TOP =
        FIELD_W'(((MAX_FIELDS - 1) < 63) ? (MAX_FIELDS - 1) : 63);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW  = 2'd2;

    localparam logic [1:0] CLASS_NAMES = 2'd0;
    localparam logic [1:0] CLASS_TYPES = 2'd1;
    localparam logic [1:0] CLASS_DATA  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [7:0]         field_char;
        logic [1:0]         row_class;
        logic [FIELD_W-1:0] field_number;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic               inside_quotes;
        logic               quote_pending;
        logic               return_pending;
        logic               line_has_content;
        logic [1:0]         rows_seen_class;
        logic [FIELD_W-1:0] field_counter;
    } tok_state_t;

    typedef struct packed {
        logic [1:0]      count;
        out_item_t [1:0] events;
    } step_out_t;

    function automatic out_item_t mk_event(
        input logic [1:0]         kind,
        input logic [7:0]         ch,
        input logic [1:0]         cls,
        input logic [FIELD_W-1:0] fnum
    );
        out_item_t ev;
        ev.event_kind   = kind;
        ev.field_char   = (kind == KIND_CHAR) ? ch : 8'd0;
        ev.row_class    = cls;
        ev.field_number = fnum;
        ev.last_of_run  = 1'b0;
        return ev;
    endfunction

endpackage

// ===== hdl/csvtok_step.sv =====
module csvtok_step (
    input  csvtok_pkg::tok_state_t st,
    input  csvtok_pkg::in_item_t   item,
    output csvtok_pkg::tok_state_t st_next,
    output csvtok_pkg::step_out_t  res
);
    import csvtok_pkg::*;

    always_comb begin
        tok_state_t      s;
        out_item_t [1:0] evs;
        logic [1:0]      n;
        logic            done;
        logic [7:0]      c;

        s    = st;
        evs  = '0;
        n    = 2'd0;
        done = 1'b0;
        c    = item.text_byte;

        if (item.end_of_text || (c == CH_NEWLINE)) begin
            if (s.line_has_content) begin
                evs[0] = mk_event(KIND_ROW, 8'd0, s.rows_seen_class, s.field_counter);
                n = 2'd1;
                if (s.rows_seen_class < CLASS_DATA) begin
                    s.rows_seen_class = s.rows_seen_class + 2'd1;
                end
            end
            s.inside_quotes    = 1'b0;
            s.quote_pending    = 1'b0;
            s.return_pending   = 1'b0;
            s.line_has_content = 1'b0;
            s.field_counter    = '0;
            if (item.end_of_text) begin
                s.rows_seen_class = CLASS_NAMES;
            end
        end else begin
            if (s.return_pending) begin
                s.return_pending   = 1'b0;
                s.line_has_content = 1'b1;
                evs[n[0]] = mk_event(KIND_CHAR, CH_RETURN, s.rows_seen_class,
                                     s.field_counter);
                n = n + 2'd1;
            end
            if (s.quote_pending) begin
                s.quote_pending = 1'b0;
                if (c == CH_QUOTE) begin
                    evs[n[0]] = mk_event(KIND_CHAR, CH_QUOTE, s.rows_seen_class,
                                         s.field_counter);
                    n = n + 2'd1;
                    done = 1'b1;
                end else begin
                    s.inside_quotes = 1'b0;
                end
            end
            if (!done) begin
                if (c == CH_RETURN) begin
                    s.return_pending = 1'b1;
                end else begin
                    s.line_has_content = 1'b1;
                    if (s.inside_quotes) begin
                        if (c == CH_QUOTE) begin
                            s.quote_pending = 1'b1;
                        end else begin
                            evs[n[0]] = mk_event(KIND_CHAR, c, s.rows_seen_class,
                                                 s.field_counter);
                            n = n + 2'd1;
                        end
                    end else if (c == CH_QUOTE) begin
                        s.inside_quotes = 1'b1;
                    end else if (c == CH_COMMA) begin
                        evs[n[0]] = mk_event(KIND_FIELD, 8'd0, s.rows_seen_class,
                                             s.field_counter);
                        n = n + 2'd1;
                        if (s.field_counter < FIELD_TOP) begin
                            s.field_counter = s.field_counter + FIELD_W'(1);
                        end
                    end else begin
                        evs[n[0]] = mk_event(KIND_CHAR, c, s.rows_seen_class,
                                             s.field_counter);
                        n = n + 2'd1;
                    end
                end
            end
        end

        if (n == 2'd1) begin
            evs[0].last_of_run = 1'b1;
        end else if (n == 2'd2) begin
            evs[1].last_of_run = 1'b1;
        end

        st_next    = s;
        res.count  = n;
        res.events = evs;
    end

endmodule

// ===== hdl/csvtok_oq.sv =====
module csvtok_oq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  csvtok_pkg::step_out_t push,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output csvtok_pkg::out_item_t m_data
);
    import csvtok_pkg::*;

    out_item_t           entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_next;
    logic [OQ_PTR_W:0]   count_reg;
    logic [OQ_PTR_W:0]   count_next;
    logic                pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign room    = (count_reg <= (OQ_PTR_W + 1)'(OQ_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
    assign count_next  = count_reg + (OQ_PTR_W + 1)'(push.count)
                       - (OQ_PTR_W + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.events[0];
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + OQ_PTR_W'(1)] <= push.events[1];
        end
    end

endmodule

// ===== hdl/csv_quoted_field_tokenizer_unit.sv =====
// Channel | Ports                      | Transfer unit
// input   | s_valid, s_ready, s_data   | one text byte or an end of text mark
// result  | m_valid, m_ready, m_data   | one token: character, field end or row end
//
// One byte per cycle while the queue has room: a byte waits in the input register, then its
// tokens (up to two) go together into a four-entry result queue.
// The first token reaches m_data through the input register and then the result queue.
// s_ready drops only while the queue holds more than two tokens.
// aresetn is synchronous, active low; it empties the queue and clears all parse state.
`include "csv_quoted_field_tokenizer_unit_macros.svh"

module csv_quoted_field_tokenizer_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csvtok_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output csvtok_pkg::out_item_t m_data
);
    import csvtok_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    in_item_t   in_data_reg;
    tok_state_t state_reg;
    tok_state_t state_next;
    step_out_t  step_res;
    step_out_t  push;
    logic       room;
    logic       advance;
    logic       s_xfer;

    assign s_ready = !in_valid_reg || room;
    assign s_xfer  = s_valid && s_ready;
    assign advance = in_valid_reg && room;

    assign in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_comb begin
        push = step_res;
        if (!advance) begin
            push.count = 2'd0;
        end
    end

    csvtok_step u_step (
        .st      (state_reg),
        .item    (in_data_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    csvtok_oq u_oq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_data;
        end
    end

    `CSVTOK_ASSERT_SAME(a_char_zero, aclk, aresetn, m_valid && (m_data.event_kind != KIND_CHAR), m_data.field_char == 8'd0)
    `CSVTOK_ASSERT_SAME(a_row_last, aclk, aresetn, m_valid && (m_data.event_kind == KIND_ROW), m_data.last_of_run)
    `CSVTOK_ASSERT_SAME(a_pend_excl, aclk, aresetn, state_reg.return_pending, !state_reg.quote_pending)
    `CSVTOK_ASSERT_NEXT(a_hold_in, aclk, aresetn, in_valid_reg && !room, in_valid_reg && $stable(in_data_reg))

endmodule

// ===== tb/tb_csv_quoted_field_tokenizer_unit.sv =====
`timescale 1ns / 100ps

module tb_csv_quoted_field_tokenizer_unit;
    import csvtok_pkg::*;

    class csv_token_scoreboard;
        logic               in_quotes    = 1'b0;
        logic               quote_held   = 1'b0;
        logic               return_held  = 1'b0;
        logic               line_started = 1'b0;
        logic [1:0]         row_class    = CLASS_NAMES;
        logic [FIELD_W-1:0] field_idx    = '0;
        out_item_t          step_tokens[$];
        out_item_t          expected_tokens[$];
        int                 errors         = 0;
        int                 tokens_checked = 0;
        int                 rows_closed    = 0;

        function void add_token(logic [1:0] kind, logic [7:0] ch);
            out_item_t tok;
            tok.event_kind   = kind;
            tok.field_char   = (kind == KIND_CHAR) ? ch : 8'd0;
            tok.row_class    = row_class;
            tok.field_number = field_idx;
            tok.last_of_run  = 1'b0;
            step_tokens = {step_tokens, tok};
        endfunction

        function void close_line();
            if (line_started) begin
                add_token(KIND_ROW, 8'd0);
                rows_closed++;
                if (row_class != CLASS_DATA) begin
                    row_class = row_class + 2'd1;
                end
            end
            in_quotes    = 1'b0;
            quote_held   = 1'b0;
            return_held  = 1'b0;
            line_started = 1'b0;
            field_idx    = '0;
        endfunction

        function void note_item(in_item_t it);
            logic [7:0] c;
            logic       consumed;
            out_item_t  tok;
            c = it.text_byte;
            consumed = 1'b0;
            step_tokens.delete();
            if (it.end_of_text) begin
                close_line();
                row_class = CLASS_NAMES;
            end else if (c == CH_NEWLINE) begin
                close_line();
            end else begin
                if (return_held) begin
                    return_held  = 1'b0;
                    line_started = 1'b1;
                    add_token(KIND_CHAR, CH_RETURN);
                end
                if (quote_held) begin
                    quote_held = 1'b0;
                    if (c == CH_QUOTE) begin
                        add_token(KIND_CHAR, CH_QUOTE);
                        consumed = 1'b1;
                    end else begin
                        in_quotes = 1'b0;
                    end
                end
                if (!consumed) begin
                    if (c == CH_RETURN) begin
                        return_held = 1'b1;
                    end else begin
                        line_started = 1'b1;
                        if (in_quotes) begin
                            if (c == CH_QUOTE) begin
                                quote_held = 1'b1;
                            end else begin
                                add_token(KIND_CHAR, c);
                            end
                        end else if (c == CH_QUOTE) begin
                            in_quotes = 1'b1;
                        end else if (c == CH_COMMA) begin
                            add_token(KIND_FIELD, 8'd0);
                            if (field_idx < FIELD_TOP) begin
                                field_idx = field_idx + FIELD_W'(1);
                            end
                        end else begin
                            add_token(KIND_CHAR, c);
                        end
                    end
                end
            end
            foreach (step_tokens[i]) begin
                tok = step_tokens[i];
                tok.last_of_run = (i == step_tokens.size() - 1);
                expected_tokens = {expected_tokens, tok};
            end
        endfunction

        function void check_token(out_item_t got);
            out_item_t want;
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected token: kind %0d char %02h class %0d field %0d last %0b",
                             got.event_kind, got.field_char, got.row_class,
                             got.field_number, got.last_of_run);
                end
            end else begin
                want = expected_tokens.pop_front();
                if (got.event_kind !== want.event_kind || got.field_char !== want.field_char ||
                    got.row_class !== want.row_class ||
                    got.field_number !== want.field_number ||
                    got.last_of_run !== want.last_of_run) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Token %0d expected kind %0d char %02h class %0d field %0d last %0b",
                                 tokens_checked, want.event_kind, want.field_char,
                                 want.row_class, want.field_number, want.last_of_run);
                        $display("Token %0d actual   kind %0d char %02h class %0d field %0d last %0b",
                                 tokens_checked, got.event_kind, got.field_char,
                                 got.row_class, got.field_number, got.last_of_run);
                    end
                end
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    csv_token_scoreboard tok_board;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int text_ends      = 0;
    int widest_row     = 0;

    csv_quoted_field_tokenizer_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tok_board.note_item(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            tok_board.check_token(m_data);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eot);
        in_item_t it;
        it.text_byte   = b;
        it.end_of_text = eot;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (eot) begin
            text_ends++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do begin
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(8'h20, 8'h7e));
        end while (b == CH_QUOTE || b == CH_COMMA || b == CH_NEWLINE || b == CH_RETURN);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0: return CH_QUOTE;
            1: return CH_COMMA;
            2: return CH_NEWLINE;
            3: return CH_RETURN;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_record();
        int n_fields;
        int len;
        int pick;
        n_fields = ($urandom_range(29) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 5);
        if (n_fields > widest_row) begin
            widest_row = n_fields;
        end
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0) begin
                send_item(CH_COMMA, 1'b0);
            end
            len = $urandom_range(0, (n_fields > 8) ? 1 : 4);
            if ($urandom_range(2) == 0) begin
                send_item(CH_QUOTE, 1'b0);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        send_item(CH_QUOTE, 1'b0);
                        send_item(CH_QUOTE, 1'b0);
                    end else if (pick == 1) begin
                        send_item(CH_COMMA, 1'b0);
                    end else if (pick == 2) begin
                        send_item(CH_RETURN, 1'b0);
                    end else if (pick == 3) begin
                        send_item(noise_byte(), 1'b0);
                    end else begin
                        send_item(plain_char(), 1'b0);
                    end
                end
                send_item(CH_QUOTE, 1'b0);
                if ($urandom_range(9) == 0) begin
                    send_item(plain_char(), 1'b0);
                end
            end else begin
                for (int k = 0; k < len; k++) begin
                    send_item(($urandom_range(14) == 0) ? CH_RETURN : plain_char(), 1'b0);
                end
            end
        end
        pick = $urandom_range(19);
        if (pick == 0) begin
            send_item(8'($urandom), 1'b1);
        end else if (pick < 6) begin
            send_item(CH_RETURN, 1'b0);
            send_item(CH_NEWLINE, 1'b0);
        end else begin
            send_item(CH_NEWLINE, 1'b0);
        end
    endtask

    initial begin
        tok_board = new;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("a,\"x\"\"y\"\015\n");
        send_text("\015\n\n\"q\"z\015");
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_text("\"a\nb");
        send_item(8'h5a, 1'b1);
        send_item(8'ha5, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            while (items_sent < 27 + (phase + 1) * 406) begin
                case ($urandom_range(11))
                    0: begin
                        repeat ($urandom_range(1, 8)) begin
                            send_item(noise_byte(), $urandom_range(15) == 0);
                        end
                    end
                    1: begin
                        if ($urandom_range(1) == 0) begin
                            send_item(CH_RETURN, 1'b0);
                        end
                        send_item(CH_NEWLINE, 1'b0);
                    end
                    default: send_record();
                endcase
            end
            // hold the sender until every pending token has been transferred
            s_valid <= 1'b0;
            do @(posedge aclk); while (tok_board.expected_tokens.size() != 0);
        end
        repeat (20) @(posedge aclk);

        if (tok_board.expected_tokens.size() != 0) begin
            tok_board.errors++;
            $display("%0d expected tokens never arrived", tok_board.expected_tokens.size());
        end
        $display("Run covered %0d byte transfers, %0d of them text ends, over four idling phases;",
                 items_sent, text_ends);
        $display("%0d tokens checked, %0d rows closed, widest generated row %0d fields.",
                 tok_board.tokens_checked, tok_board.rows_closed, widest_row);
        if (tok_board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
